/* hw/rtl/mwtg_pkg.sv */
// Shared types and constants for the multi-waveform tone generator.
// No dependencies; imported by the core.
package mwtg_pkg;

  typedef enum logic [1:0] {
    SHAPE_SINE     = 2'd0,
    SHAPE_SAW      = 2'd1,
    SHAPE_SQUARE   = 2'd2,
    SHAPE_TRIANGLE = 2'd3
  } shape_t;

  // Q15 unity, also the saturation point of the level
  localparam logic [16:0] ONE_Q15 = 17'd32768;

  // pi/2 in Q30, seed of the sine series
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Fraction bits of the frequency-to-step reciprocal; exact for 16-bit
  // frequencies and sample rates below 2^18.
  localparam int RECIP_SHIFT = 34;

endpackage

/* hw/rtl/multi_waveform_tone_generator_core.sv */
// Multi-waveform tone generator core: phase accumulator with sine, saw,
// square and triangle shapes. Depends on mwtg_pkg.
// Structure: input register, one pass of logic, output register.
// Throughput: one input transfer per cycle while in_stall is low.
//   in_stall rises only while both hold items and out_stall is high.
// Reset: synchronous; clears valids and oscillator state, samples_per_beat = 48000.
module multi_waveform_tone_generator_core
  import mwtg_pkg::*;
#(
  parameter int unsigned SAMPLE_RATE_HZ   = 48000,
  parameter int unsigned PHASE_BITS       = 32,
  parameter int unsigned SINE_TABLE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  // configuration write (samples_per_beat)
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  // input items
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               start_req,
  input  logic [1:0]         waveform,
  input  logic [15:0]        frequency,
  input  logic [15:0]        amplitude,
  input  logic [15:0]        note_beats,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] sample,
  output logic               last
);

  localparam int AW = (SINE_TABLE_DEPTH > 1) ? $clog2(SINE_TABLE_DEPTH) : 1;

  // step = floor(freq * 2^PHASE_BITS / rate) via a rounded-up reciprocal
  localparam logic [97:0] RECIP_FULL =
    ((98'd1 << (PHASE_BITS + RECIP_SHIFT)) + 98'(SAMPLE_RATE_HZ) - 98'd1)
    / 98'(SAMPLE_RATE_HZ);
  localparam logic [63:0] RECIP = RECIP_FULL[63:0];

  // start phases: half a turn for saw, three quarters for triangle
  localparam logic [PHASE_BITS-1:0] SAW_START = {1'b1, {(PHASE_BITS-1){1'b0}}};
  localparam logic [PHASE_BITS-1:0] TRI_START = {2'b11, {(PHASE_BITS-2){1'b0}}};

  typedef logic [15:0] rom_t [SINE_TABLE_DEPTH];

  // Quarter-wave sine in Q15: Taylor series to the 13th power in Q30,
  // each term truncated, the sum rounded half up.
  function automatic rom_t build_rom();
    rom_t              rom;
    logic [63:0]       theta;
    logic [63:0]       t2;
    logic [63:0]       term;
    logic [63:0]       val;
    logic signed [63:0] sum;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      theta = (64'(k) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
      t2    = (theta * theta) >> 30;
      term  = theta;
      sum   = signed'(theta);
      term  = ((term * t2) >> 30) / 64'd6;
      sum   = sum - signed'(term);
      term  = ((term * t2) >> 30) / 64'd20;
      sum   = sum + signed'(term);
      term  = ((term * t2) >> 30) / 64'd42;
      sum   = sum - signed'(term);
      term  = ((term * t2) >> 30) / 64'd72;
      sum   = sum + signed'(term);
      term  = ((term * t2) >> 30) / 64'd110;
      sum   = sum - signed'(term);
      term  = ((term * t2) >> 30) / 64'd156;
      sum   = sum + signed'(term);
      if (sum < 0) begin
        sum = 64'sd0;
      end
      val = ((unsigned'(sum) * 64'd32768) + (64'd1 << 29)) >> 30;
      if (val > 64'd32767) begin
        val = 64'd32767;
      end
      rom[k[AW-1:0]] = val[15:0];
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // ---------------------------------------------------------------------
  // Configuration: one register, always ready
  // ---------------------------------------------------------------------
  logic [15:0] samples_per_beat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_beat <= 16'd48000;
    end else if (cfg_valid && cfg_ready) begin
      samples_per_beat <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------
  // Enables: the output register loads when empty or when its transfer
  // happens; the input register loads when empty or when it drains.
  // ---------------------------------------------------------------------
  logic s1_valid;
  logic en1, en_out;

  assign en_out   = !out_valid || !out_stall;
  assign en1      = !s1_valid || en_out;
  assign in_stall = !en1;

  // ---------------------------------------------------------------------
  // Input register. Step partial products, note length and the saturated
  // level times full scale are formed from the ports on the transfer.
  // ---------------------------------------------------------------------
  logic        s1_start;
  shape_t      s1_waveform;
  logic [47:0] s1_pp_lo, s1_pp_hi;
  logic [23:0] s1_left;
  logic [29:0] s1_gain;

  logic [47:0] pp_lo, pp_hi;
  logic [31:0] left_prod;
  logic [15:0] level_sat;
  logic [29:0] gain_in;

  assign pp_lo     = 48'(frequency) * 48'(RECIP[31:0]);
  assign pp_hi     = 48'(frequency) * 48'(RECIP[63:32]);
  assign left_prod = 32'(note_beats) * 32'(samples_per_beat);
  assign level_sat = (amplitude > ONE_Q15[15:0]) ? ONE_Q15[15:0] : amplitude;
  // level * 32767 as shift and subtract; at most 32768 * 32767 < 2^30
  assign gain_in   = 30'({level_sat, 15'd0} - 31'(level_sat));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && en1) begin
      s1_start    <= start_req;
      s1_waveform <= shape_t'(waveform);
      s1_pp_lo    <= pp_lo;
      s1_pp_hi    <= pp_hi;
      s1_left     <= left_prod[31:8];
      s1_gain     <= gain_in;
    end
  end

  // ---------------------------------------------------------------------
  // Single pass: oscillator state, sample count, shape and scaling.
  // A start item replaces the whole note; its own sample uses the start
  // phase, then the phase advances by the new step.
  // ---------------------------------------------------------------------
  logic [PHASE_BITS-1:0] phase, phase_step;
  logic [23:0]           samples_left;
  shape_t                shape_select;
  logic [29:0]           gain;          // level times 32767

  logic [79:0]           step_sum;
  logic [PHASE_BITS-1:0] step_new, start_phase;
  logic [PHASE_BITS-1:0] cur_phase, cur_step;
  logic [23:0]           cur_left, left_dec;
  shape_t                cur_shape;
  logic [29:0]           cur_gain;
  logic                  emit;
  logic [15:0]           u;
  logic [15:0]           tri_dist;
  logic [16:0]           tri_dist2;
  logic [14+AW-1:0]      j_prod;
  logic [AW-1:0]         j_idx;
  logic [AW:0]           j_mirror;
  logic                  sine_full;
  logic [AW-1:0]         rom_addr;
  logic [16:0]           mag;
  logic                  neg;
  logic [46:0]           prod;
  logic [15:0]           mag_out;
  logic signed [15:0]    sample_next;

  assign step_sum = {s1_pp_hi, 32'd0} + {32'd0, s1_pp_lo};
  assign step_new = step_sum[RECIP_SHIFT+PHASE_BITS-1:RECIP_SHIFT];

  always_comb begin
    case (s1_waveform)
      SHAPE_SAW:      start_phase = SAW_START;
      SHAPE_TRIANGLE: start_phase = TRI_START;
      default:        start_phase = '0;
    endcase
  end

  assign cur_shape = s1_start ? s1_waveform : shape_select;
  assign cur_phase = s1_start ? start_phase : phase;
  assign cur_step  = s1_start ? step_new    : phase_step;
  assign cur_left  = s1_start ? s1_left     : samples_left;
  assign cur_gain  = s1_start ? s1_gain     : gain;
  assign emit      = (cur_left != 24'd0);
  assign left_dec  = cur_left - 24'd1;
  assign u         = cur_phase[PHASE_BITS-1 -: 16];

  // sine index: j = u[13:0] * depth / 2^14, mirrored in odd quadrants
  assign j_prod    = (14+AW)'(u[13:0]) * (14+AW)'(SINE_TABLE_DEPTH);
  assign j_idx     = j_prod[14+AW-1:14];
  assign j_mirror  = (AW+1)'(SINE_TABLE_DEPTH) - {1'b0, j_idx};
  assign sine_full = u[14] && (j_idx == '0);
  assign rom_addr  = u[14] ? j_mirror[AW-1:0] : j_idx;

  assign tri_dist  = u[15] ? {1'b0, u[14:0]} : (16'd32768 - u);
  assign tri_dist2 = {tri_dist, 1'b0};

  always_comb begin
    mag = '0;
    neg = 1'b0;
    case (cur_shape)
      SHAPE_SINE: begin
        // mirrored index of zero is the peak, one past the table
        mag = sine_full ? ONE_Q15 : {1'b0, SINE_ROM[rom_addr]};
        neg = u[15];
      end
      SHAPE_SAW: begin
        if (u[15]) begin
          mag = {2'b00, u[14:0]};
        end else begin
          mag = ONE_Q15 - {1'b0, u};
          neg = 1'b1;
        end
      end
      SHAPE_SQUARE: begin
        mag = ONE_Q15;
        neg = u[15];
      end
      default: begin  // triangle
        if (tri_dist2 >= ONE_Q15) begin
          mag = tri_dist2 - ONE_Q15;
        end else begin
          mag = ONE_Q15 - tri_dist2;
          neg = 1'b1;
        end
      end
    endcase
  end

  // gain * shape, drop 30 bits; magnitude never exceeds 32767
  assign prod        = 47'(cur_gain) * 47'(mag);
  assign mag_out     = prod[45:30];
  assign sample_next = neg ? -signed'(mag_out) : signed'(mag_out);

  // state moves with the item that leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= '0;
      phase_step   <= '0;
      samples_left <= '0;
      shape_select <= SHAPE_SINE;
      gain         <= '0;
    end else if (s1_valid && en_out) begin
      shape_select <= cur_shape;
      gain         <= cur_gain;
      phase_step   <= cur_step;
      samples_left <= emit ? left_dec : cur_left;
      phase        <= emit ? (cur_phase + cur_step) : cur_phase;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_out) begin
      out_valid <= s1_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      sample <= sample_next;
      last   <= (cur_left == 24'd1);
    end
  end

endmodule
